// File: hdl/adaptive_threshold_binarizer_top_assert.svh
// Assertion macros for the adaptive threshold binarizer
`ifndef ADAPTIVE_THRESHOLD_BINARIZER_TOP_ASSERT_SVH
`define ADAPTIVE_THRESHOLD_BINARIZER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define ATB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define ATB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/atb_pkg.sv
//------------------------------------------------------------------------------
// atb_pkg
// Shared types and constants of the adaptive threshold binarizer.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package atb_pkg;
	localparam int MaxWidthDef  = 256;
	localparam int MaxHeightDef = 256;
	localparam int DimW   = 9;
	localparam int KW     = 17;
	localparam int CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_WEIGHT = 2'd2;
	localparam logic [DimW-1:0] WidthRst  = 9'd256;
	localparam logic [DimW-1:0] HeightRst = 9'd256;
	localparam logic [KW-1:0]   WeightRst = 17'd19661;
	localparam logic [KW-1:0]   QOne      = 17'd65536;
	localparam logic [7:0] BLACK = 8'd0;
	localparam logic [7:0] WHITE = 8'd255;

	typedef struct packed {
		logic       mode;
		logic [7:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [7:0] binary_value;
		logic       last;
	} out_item_t;
endpackage
`default_nettype wire

// File: hdl/adaptive_threshold_binarizer_top.sv
//------------------------------------------------------------------------------
// adaptive_threshold_binarizer_top
// Integral-image adaptive threshold binarizer with queue-style channels.
//------------------------------------------------------------------------------
// Usage: push items while full is low. Mode 0 loads pixels in raster order;
// after the whole frame is loaded, each mode 1 request yields one output
// (0 or 255) on the result side, with last set on the final pixel.
// A mode 1 request with no complete frame gives no result.
// A load steps through a read and a write state; a read takes four
// integral RAM reads and the bit-serial mean division (skipped when the
// window is empty); the RAM read sequence and the divider set the rate.
// Results wait in one output register until pop; while it is full the
// back end stalls and full rises once the command register is occupied.
// Reset clears positions, the frame minimum and all control state; the
// pixel and integral memories are not cleared; read commands use them only
// after a complete frame was written. Configuration writes are always ready;
// width or height writes restart loading.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "adaptive_threshold_binarizer_top_assert.svh"
module adaptive_threshold_binarizer_top
	import atb_pkg::*;
#(
	parameter int MaxWidth  = MaxWidthDef,
	parameter int MaxHeight = MaxHeightDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire in_item_t           in_item,
	output logic                    full,
	output logic                    empty,
	input  wire logic               pop,
	output out_item_t               out_item,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [KW-1:0]      cfg_data
);
	logic [DimW-1:0] width_q, height_q;
	logic [KW-1:0] weight_q;
	logic restart;
	logic cmd_valid, cmd_ready, cmd_load, cmd_first;
	logic [7:0] cmd_pixel;
	logic [$clog2(MaxWidth)-1:0] cmd_x;
	logic [$clog2(MaxHeight)-1:0] cmd_y;

	assign cfg_ready = 1'b1;
	assign restart = cfg_valid &&
		(cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WidthRst; height_q <= HeightRst; weight_q <= WeightRst;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DimW-1:0];
				REG_HEIGHT: height_q <= cfg_data[DimW-1:0];
				REG_WEIGHT: weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	atb_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .in_item(in_item),
		.full(full), .restart(restart), .width(width_q), .height(height_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_load(cmd_load),
		.cmd_pixel(cmd_pixel), .cmd_x(cmd_x), .cmd_y(cmd_y),
		.cmd_first(cmd_first));

	atb_back #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_back (
		.clk(clk), .arst_n(arst_n), .width(width_q), .height(height_q),
		.weight(weight_q), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.cmd_load(cmd_load), .cmd_pixel(cmd_pixel), .cmd_x(cmd_x),
		.cmd_y(cmd_y), .cmd_first(cmd_first), .empty(empty), .pop(pop),
		.out_item(out_item));

	`ATB_ASSERT_NXT(a_pop_drains, pop && !empty && !cmd_valid, empty, "result not drained")
	`ATB_ASSERT_IMP(a_full_means_pending, full, cmd_valid, "full without command")
	`ATB_ASSERT_NXT(a_result_holds, !empty && !pop, $stable(out_item), "result changed")
endmodule
`default_nettype wire

// File: hdl/atb_ram.sv
//------------------------------------------------------------------------------
// atb_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module atb_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/atb_divider.sv
//------------------------------------------------------------------------------
// atb_divider
// Restoring divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module atb_divider #(
	parameter int NW = 24,
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic               done,
	output logic      [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], num_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	// control: count down quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) cnt_q <= CW'(NW);
			else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done <= 1'b1;
			end
		end
	end
	// datapath: shift in one bit, subtract if it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NW-2:0], ~trial[DW]};
			rem_q <= trial[DW] ? shifted : trial;
		end
	end
	assign busy = (cnt_q != '0);
	assign quo  = num_q;
endmodule
`default_nettype wire

// File: hdl/atb_front.sv
//------------------------------------------------------------------------------
// atb_front
// Accepts items, tracks frame position, classifies each item as a load or
// a read command for the command register; frameless reads are dropped.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module atb_front
	import atb_pkg::*;
#(
	parameter int MaxWidth  = MaxWidthDef,
	parameter int MaxHeight = MaxHeightDef
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire in_item_t       in_item,
	output logic                full,
	input  wire logic           restart,
	input  wire logic [DimW-1:0] width,
	input  wire logic [DimW-1:0] height,
	output logic                cmd_valid,
	input  wire logic           cmd_ready,
	output logic                cmd_load,
	output logic [7:0]          cmd_pixel,
	output logic [$clog2(MaxWidth)-1:0]  cmd_x,
	output logic [$clog2(MaxHeight)-1:0] cmd_y,
	output logic                cmd_first
);
	localparam int XW = $clog2(MaxWidth);
	localparam int YW = $clog2(MaxHeight);
	logic [XW:0] x_q;
	logic [YW:0] y_q;
	logic        loading_q;
	logic        ready_q;
	logic [XW:0] w_eff;
	logic [YW:0] h_eff;
	logic        acc;
	logic        x_end;
	logic        y_end;

	// clamp dimensions to [1, max]
	always_comb begin
		w_eff = (width == '0) ? (XW+1)'(1) :
			(32'(width) > MaxWidth) ? (XW+1)'(MaxWidth) : (XW+1)'(width);
		h_eff = (height == '0) ? (YW+1)'(1) :
			(32'(height) > MaxHeight) ? (YW+1)'(MaxHeight) : (YW+1)'(height);
	end

	assign full  = cmd_valid && !cmd_ready;
	assign acc   = push && !full;
	assign x_end = (x_q + 1'b1 == w_eff);
	assign y_end = (y_q + 1'b1 == h_eff);

	// advance position and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; loading_q <= 1'b1; ready_q <= 1'b0;
			cmd_valid <= 1'b0;
		end else begin
			if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
			if (restart) begin
				x_q <= '0; y_q <= '0; loading_q <= 1'b1; ready_q <= 1'b0;
			end else if (acc) begin
				if (!in_item.mode) begin
					cmd_valid <= 1'b1;
					if (!loading_q || ready_q) begin
						// drop old frame and start with this pixel
						ready_q <= (w_eff == 1 && h_eff == 1);
						loading_q <= !(w_eff == 1 && h_eff == 1);
						x_q <= (w_eff == 1) ? '0 : (XW+1)'(1);
						y_q <= (w_eff == 1 && h_eff != 1) ? (YW+1)'(1) : '0;
					end else if (x_end) begin
						x_q <= '0;
						if (y_end) begin
							y_q <= '0; loading_q <= 1'b0; ready_q <= 1'b1;
						end else y_q <= y_q + 1'b1;
					end else x_q <= x_q + 1'b1;
				end else if (ready_q) begin
					cmd_valid <= 1'b1;
					if (x_end) begin
						x_q <= '0;
						if (y_end) begin
							y_q <= '0; ready_q <= 1'b0;
						end else y_q <= y_q + 1'b1;
					end else x_q <= x_q + 1'b1;
				end
			end
		end
	end

	// capture command payload
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_load  <= !in_item.mode;
			cmd_pixel <= in_item.pixel;
			cmd_first <= !loading_q || ready_q || (x_q == '0 && y_q == '0);
			if (!in_item.mode && (!loading_q || ready_q)) begin
				cmd_x <= '0; cmd_y <= '0;
			end else begin
				cmd_x <= x_q[XW-1:0]; cmd_y <= y_q[YW-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/atb_back.sv
//------------------------------------------------------------------------------
// atb_back
// Executes load and read commands: integral image build, window sum,
// mean division, threshold and output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module atb_back
	import atb_pkg::*;
#(
	parameter int MaxWidth  = MaxWidthDef,
	parameter int MaxHeight = MaxHeightDef
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [DimW-1:0] width,
	input  wire logic [DimW-1:0] height,
	input  wire logic [KW-1:0]   weight,
	input  wire logic            cmd_valid,
	output logic                 cmd_ready,
	input  wire logic            cmd_load,
	input  wire logic [7:0]      cmd_pixel,
	input  wire logic [$clog2(MaxWidth)-1:0]  cmd_x,
	input  wire logic [$clog2(MaxHeight)-1:0] cmd_y,
	input  wire logic            cmd_first,
	output logic                 empty,
	input  wire logic            pop,
	output out_item_t            out_item
);
	localparam int XW = $clog2(MaxWidth);
	localparam int YW = $clog2(MaxHeight);
	localparam int AW = XW + YW;
	localparam int Depth = MaxWidth * MaxHeight;
	localparam int IW = 24;
	localparam int CNW = XW + YW;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LRD  = 9'b000000010,
		ST_LWR  = 9'b000000100,
		ST_R0   = 9'b000001000,
		ST_R1   = 9'b000010000,
		ST_R2   = 9'b000100000,
		ST_R3   = 9'b001000000,
		ST_DIV  = 9'b010000000,
		ST_THR  = 9'b100000000
	} st_t;
	st_t st_q;

	logic [XW:0] w_eff;
	logic [YW:0] h_eff;
	logic [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic [XW-1:0] cx;
	logic [YW-1:0] cy;
	logic [7:0] pix_q;
	logic [15:0] row_q;
	logic [7:0] min_q;
	logic [AW-1:0] raddr;
	logic [IW-1:0] irdata;
	logic [7:0] prdata;
	logic iwe;
	logic [IW-1:0] iwdata;
	logic [IW-1:0] sum_q;
	logic [IW-1:0] sum_fin;
	logic [XW-1:0] x1, x2;
	logic [YW-1:0] y1, y2;
	logic [XW-1:0] half;
	logic [CNW-1:0] cnt_q;
	logic [2:0] rd_sel;
	logic div_start, div_busy, div_done;
	logic [IW-1:0] quo;
	logic [IW-1:0] mean_q;
	logic [KW-1:0] k_eff;
	logic [40:0] thr_a;
	logic [40:0] thr_b;
	logic [7:0] p_q;
	logic last_q;
	logic [15:0] row_new;

	// window corners; while idle they follow the incoming command position
	always_comb begin
		w_eff = (width == '0) ? (XW+1)'(1) :
			(32'(width) > MaxWidth) ? (XW+1)'(MaxWidth) : (XW+1)'(width);
		h_eff = (height == '0) ? (YW+1)'(1) :
			(32'(height) > MaxHeight) ? (YW+1)'(MaxHeight) : (YW+1)'(height);
		cx = (st_q == ST_IDLE) ? cmd_x : x_q;
		cy = (st_q == ST_IDLE) ? cmd_y : y_q;
		half = XW'(w_eff >> 3);
		x1 = (cx >= half) ? cx - half : '0;
		y1 = (32'(cy) >= 32'(half)) ? YW'(32'(cy) - 32'(half)) : '0;
		x2 = ((XW+1)'(cx) + (XW+1)'(half) >= w_eff) ? XW'(w_eff - 1'b1) : cx + half;
		y2 = (32'(cy) + 32'(half) >= 32'(h_eff)) ? YW'(h_eff - 1'b1) :
			YW'(32'(cy) + 32'(half));
		k_eff = (weight > QOne) ? QOne : weight;
		row_new = ((x_q == '0) ? 16'd0 : row_q) + 16'(pix_q);
		thr_a = 41'(QOne - k_eff) * 41'(mean_q);
		thr_b = 41'(k_eff) * 41'(min_q);
	end

	// address select: row-major index y*w + x
	always_comb begin
		logic [XW-1:0] ax;
		logic [YW-1:0] ay;
		ax = x_q; ay = y_q;
		unique case (rd_sel)
			3'd0: begin ax = x2; ay = y2; end
			3'd1: begin ax = x2; ay = y1; end
			3'd2: begin ax = x1; ay = y2; end
			3'd3: begin ax = x1; ay = y1; end
			3'd4: begin ax = x_q; ay = y_q - 1'b1; end
			default: begin ax = x_q; ay = y_q; end
		endcase
		raddr = AW'(32'(ay) * 32'(w_eff) + 32'(ax));
	end

	logic [AW-1:0] waddr;
	assign waddr = AW'(32'(cy) * 32'(w_eff) + 32'(cx));
	assign iwdata = ((y_q == '0) ? '0 : irdata) + IW'(row_new);
	assign sum_fin = sum_q + irdata;

	atb_ram #(.Width(IW), .Depth(Depth)) u_iram (
		.clk(clk), .we(iwe), .waddr(waddr), .wdata(iwdata),
		.raddr(raddr), .rdata(irdata));
	atb_ram #(.Width(8), .Depth(Depth)) u_pram (
		.clk(clk), .we(iwe), .waddr(waddr), .wdata(pix_q),
		.raddr(waddr), .rdata(prdata));

	atb_divider #(.NW(IW), .DW(IW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_fin), .den(IW'(cnt_q)), .busy(div_busy),
		.done(div_done), .quo(quo));

	assign iwe = (st_q == ST_LWR);
	assign cmd_ready = (st_q == ST_IDLE) && empty;
	assign div_start = (st_q == ST_R3) && (cnt_q != '0);

	// select read address by state
	always_comb begin
		unique case (st_q)
			ST_LRD: rd_sel = 3'd4;
			ST_R0:  rd_sel = 3'd1;
			ST_R1:  rd_sel = 3'd2;
			ST_R2:  rd_sel = 3'd3;
			default: rd_sel = 3'd0;
		endcase
	end

	// sequence load and read commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; empty <= 1'b1; min_q <= 8'hFF; row_q <= '0;
		end else begin
			if (pop && !empty) empty <= 1'b1;
			unique case (st_q)
				ST_IDLE: if (cmd_valid && cmd_ready) begin
					st_q <= cmd_load ? ST_LRD : ST_R0;
					if (cmd_load && cmd_first) min_q <= 8'hFF;
				end
				ST_LRD: st_q <= ST_LWR;
				ST_LWR: begin
					row_q <= row_new;
					if (pix_q < min_q) min_q <= pix_q;
					st_q <= ST_IDLE;
				end
				ST_R0: st_q <= ST_R1;
				ST_R1: st_q <= ST_R2;
				ST_R2: st_q <= ST_R3;
				ST_R3: st_q <= (cnt_q != '0) ? ST_DIV : ST_THR;
				ST_DIV: if (div_done) st_q <= ST_THR;
				ST_THR: begin
					empty <= 1'b0; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (cmd_valid && cmd_ready) begin
				x_q <= cmd_x; y_q <= cmd_y; pix_q <= cmd_pixel;
				last_q <= (32'(cmd_x) + 1 == 32'(w_eff)) &&
					(32'(cmd_y) + 1 == 32'(h_eff));
			end
			ST_R0: begin
				sum_q <= irdata;
				cnt_q <= CNW'(32'(y2 - y1) * 32'(x2 - x1));
				p_q <= prdata;
			end
			ST_R1: sum_q <= sum_q - irdata;
			ST_R2: sum_q <= sum_q - irdata;
			ST_R3: begin
				sum_q <= sum_fin;
				mean_q <= '0;
			end
			ST_DIV: if (div_done) mean_q <= quo;
			default: ;
		endcase
		if (st_q == ST_THR) begin
			out_item.binary_value <=
				(41'(p_q) <= ((thr_a + thr_b) >> 16)) ? BLACK : WHITE;
			out_item.last <= last_q;
		end
	end

	logic unused;
	assign unused = div_busy;
endmodule
`default_nettype wire
